>>> sv/exact_vertex_weld_unit_assert.svh
// Assertion macros for the bound checker
`ifndef EXACT_VERTEX_WELD_UNIT_ASSERT_SVH
`define EXACT_VERTEX_WELD_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante
`define EVW_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Check cons in the cycle after ante
`define EVW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

>>> sv/evw_pkg.sv
package evw_pkg;

   // Default store capacity
   localparam int EVW_MAX_VERTICES = 16384;

   // Fixed field widths
   localparam int COORD_W  = 32;
   localparam int PARENT_W = 14;
   localparam int COUNT_W  = 15;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;   // take the accepted word, restart the scan
      logic scan;   // walk the store one entry per cycle
      logic emit;   // update counters, store, and result register
   } evw_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic vtx_full;     // vertex counter saturated at capacity
      logic store_empty;  // no distinct vertex stored yet
      logic hit;          // compared entry equals the vertex
      logic scan_end;     // compared entry was the last stored one
      logic out_free;     // result register can take a word
   } evw_sts_type;

endpackage

>>> sv/exact_vertex_weld_unit.sv
// Flow: a vertex word is taken only in idle. When the store is empty or the mesh has
// overflowed, the result is registered without a scan; otherwise the store is walked one
// entry per cycle until a match or the last stored entry. A stalled result word holds the unit.
// Throughput: one vertex at a time; the next word is taken only after the result is
// registered and the unit is back in idle.
// Reset clears the counters and the overflow flag; the store keeps its contents.
module exact_vertex_weld_unit import evw_pkg::*; #(
   parameter int MAX_VERTICES = EVW_MAX_VERTICES
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [COORD_W-1:0]  req_coord_x,
   input  logic [COORD_W-1:0]  req_coord_y,
   input  logic [COORD_W-1:0]  req_coord_z,
   input  logic                req_final_vertex,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PARENT_W-1:0] rsp_parent_index,
   output logic [COUNT_W-1:0]  rsp_distinct_count,
   output logic                rsp_overflow,
   output logic                rsp_final_result
);

   evw_cmd_type cmd;
   evw_sts_type sts;

   evw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   evw_dp #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .req_coord_z        (req_coord_z),
      .req_final_vertex   (req_final_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_parent_index   (rsp_parent_index),
      .rsp_distinct_count (rsp_distinct_count),
      .rsp_overflow       (rsp_overflow),
      .rsp_final_result   (rsp_final_result)
   );

endmodule

>>> sv/evw_ctrl.sv
module evw_ctrl import evw_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  evw_sts_type sts,
   output evw_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_EMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   // Decode commands from the current state
   always_comb begin
      cmd      = '0;
      cmd.load = (state_ff == S_IDLE) && req_valid;
      cmd.scan = (state_ff == S_SCAN);
      cmd.emit = (state_ff == S_EMIT) && sts.out_free;
   end

   // Advance the sequence
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (sts.vtx_full || sts.store_empty) begin
                  state_in = S_EMIT;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (sts.hit || sts.scan_end) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> sv/evw_dp.sv
module evw_dp import evw_pkg::*; #(
   parameter int MAX_VERTICES = EVW_MAX_VERTICES
) (
   input  logic                clock,
   input  logic                reset,
   input  evw_cmd_type         cmd,
   output evw_sts_type         sts,
   input  logic [COORD_W-1:0]  req_coord_x,
   input  logic [COORD_W-1:0]  req_coord_y,
   input  logic [COORD_W-1:0]  req_coord_z,
   input  logic                req_final_vertex,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [PARENT_W-1:0] rsp_parent_index,
   output logic [COUNT_W-1:0]  rsp_distinct_count,
   output logic                rsp_overflow,
   output logic                rsp_final_result
);

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = IDX_W + 1;
   localparam int ENT_W = 3 * COORD_W + IDX_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);

   // Value equality on single precision patterns: signed zeros match, NaN never
   function automatic logic f_single_eq(input logic [COORD_W-1:0] a,
                                        input logic [COORD_W-1:0] b);
      logic a_nan;
      logic b_nan;
      a_nan = (a[30:23] == 8'hFF) && (a[22:0] != '0);
      b_nan = (b[30:23] == 8'hFF) && (b[22:0] != '0);
      return !a_nan && !b_nan && ((a == b) || ((a[30:0] == '0) && (b[30:0] == '0)));
   endfunction

   // Distinct vertex store: {x, y, z, origin}
   logic [ENT_W-1:0] store_mem [MAX_VERTICES];
   logic [ENT_W-1:0] rd_data_ff;

   logic [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic               last_ff;

   logic [CNT_W-1:0] vcount_ff, vcount_in;
   logic [CNT_W-1:0] dcount_ff, dcount_in;
   logic             ovf_ff, ovf_in;

   logic [CNT_W-1:0] issue_ptr_ff, issue_ptr_in;
   logic             cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] origin_ff, origin_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [PARENT_W-1:0] rsp_parent_ff, rsp_parent_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                rsp_ovf_ff, rsp_ovf_in;
   logic                rsp_last_ff, rsp_last_in;

   logic             rd_en;
   logic             wr_en;
   logic             match;
   logic [IDX_W-1:0] parent_sel;
   logic [CNT_W-1:0] dcount_next;
   logic             ovf_next;

   // Issue one store read per cycle while entries remain
   assign rd_en = cmd.scan && (issue_ptr_ff < dcount_ff);

   // Compare the entry read in the previous cycle
   assign match = cmp_valid_ff
                  && f_single_eq(rd_data_ff[ENT_W-1 -: COORD_W], x_ff)
                  && f_single_eq(rd_data_ff[ENT_W-1-COORD_W -: COORD_W], y_ff)
                  && f_single_eq(rd_data_ff[ENT_W-1-2*COORD_W -: COORD_W], z_ff);

   assign wr_en = cmd.emit && !sts.vtx_full && !found_ff && (dcount_ff < MAX_CNT);

   always_comb begin
      sts             = '0;
      sts.vtx_full    = (vcount_ff >= MAX_CNT);
      sts.store_empty = (dcount_ff == '0);
      sts.hit         = match;
      sts.scan_end    = cmp_valid_ff
                        && ((CNT_W'(cmp_idx_ff) + CNT_W'(1)) == dcount_ff);
      sts.out_free    = !rsp_valid_ff || rsp_ready;
   end

   // Scan pointers and match capture
   always_comb begin
      issue_ptr_in = issue_ptr_ff;
      cmp_valid_in = cmp_valid_ff;
      cmp_idx_in   = cmp_idx_ff;
      found_in     = found_ff;
      origin_in    = origin_ff;
      if (cmd.load) begin
         issue_ptr_in = '0;
         cmp_valid_in = 1'b0;
         found_in     = 1'b0;
      end else if (cmd.scan) begin
         cmp_valid_in = rd_en;
         if (rd_en) begin
            issue_ptr_in = issue_ptr_ff + CNT_W'(1);
            cmp_idx_in   = issue_ptr_ff[IDX_W-1:0];
         end
         if (match) begin
            found_in  = 1'b1;
            origin_in = rd_data_ff[IDX_W-1:0];
         end
      end
   end

   // Resolve the result and the counter updates
   always_comb begin
      if (sts.vtx_full) begin
         parent_sel  = '0;
         dcount_next = dcount_ff;
         ovf_next    = 1'b1;
      end else begin
         parent_sel  = found_ff ? origin_ff : vcount_ff[IDX_W-1:0];
         dcount_next = wr_en ? dcount_ff + CNT_W'(1) : dcount_ff;
         ovf_next    = ovf_ff;
      end

      vcount_in     = vcount_ff;
      dcount_in     = dcount_ff;
      ovf_in        = ovf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_parent_in = rsp_parent_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_last_in   = rsp_last_ff;
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_parent_in = PARENT_W'(parent_sel);
         rsp_count_in  = COUNT_W'(dcount_next);
         rsp_ovf_in    = ovf_next;
         rsp_last_in   = last_ff;
         if (last_ff) begin
            vcount_in = '0;
            dcount_in = '0;
            ovf_in    = 1'b0;
         end else begin
            vcount_in = sts.vtx_full ? vcount_ff : vcount_ff + CNT_W'(1);
            dcount_in = dcount_next;
            ovf_in    = ovf_next;
         end
      end
   end

   // Write and read the store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[dcount_ff[IDX_W-1:0]] <= {x_ff, y_ff, z_ff, vcount_ff[IDX_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_mem[issue_ptr_ff[IDX_W-1:0]];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff    <= '0;
         dcount_ff    <= '0;
         ovf_ff       <= 1'b0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         vcount_ff    <= vcount_in;
         dcount_ff    <= dcount_in;
         ovf_ff       <= ovf_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= req_coord_x;
         y_ff    <= req_coord_y;
         z_ff    <= req_coord_z;
         last_ff <= req_final_vertex;
      end
      issue_ptr_ff  <= issue_ptr_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_ff      <= found_in;
      origin_ff     <= origin_in;
      rsp_parent_ff <= rsp_parent_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_parent_index   = rsp_parent_ff;
   assign rsp_distinct_count = rsp_count_ff;
   assign rsp_overflow       = rsp_ovf_ff;
   assign rsp_final_result   = rsp_last_ff;

endmodule

>>> sv/evw_checker.sv
`include "exact_vertex_weld_unit_assert.svh"

module evw_checker import evw_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [COORD_W-1:0]  req_coord_x,
   input logic [COORD_W-1:0]  req_coord_y,
   input logic [COORD_W-1:0]  req_coord_z,
   input logic                req_final_vertex,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [PARENT_W-1:0] rsp_parent_index,
   input logic [COUNT_W-1:0]  rsp_distinct_count,
   input logic                rsp_overflow,
   input logic                rsp_final_result
);

   // Hold a stalled result word
   `EVW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_parent_index) && $stable(rsp_distinct_count)
      && $stable(rsp_overflow) && $stable(rsp_final_result))

   // An overflowed vertex is never compared, so its parent is zero
   `EVW_ASSERT_NOW(a_ovf_parent, clock, reset, rsp_valid && rsp_overflow,
      rsp_parent_index == '0)

   // A vertex inside capacity always leaves at least one distinct vertex
   `EVW_ASSERT_NOW(a_count_nonzero, clock, reset, rsp_valid && !rsp_overflow,
      rsp_distinct_count != '0)

   // One vertex at a time: no new word is taken in the cycle after one is taken
   `EVW_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready,
      !req_ready)

endmodule

bind exact_vertex_weld_unit evw_checker u_evw_checker (.*);

>>> tb/sv/exact_vertex_weld_checker.sv
// Watches both channels of the weld unit, predicts every result word from the
// accepted vertex words, and compares field by field in arrival order.
module exact_vertex_weld_checker import evw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [COORD_W-1:0]  req_coord_x,
   input  logic [COORD_W-1:0]  req_coord_y,
   input  logic [COORD_W-1:0]  req_coord_z,
   input  logic                req_final_vertex,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [PARENT_W-1:0] rsp_parent_index,
   input  logic [COUNT_W-1:0]  rsp_distinct_count,
   input  logic                rsp_overflow,
   input  logic                rsp_final_result,
   output int unsigned         mismatches,
   output int unsigned         pending,
   output int unsigned         results_checked,
   output int unsigned         overflow_results
);

   localparam int CAPACITY = EVW_MAX_VERTICES;

   typedef struct packed {
      logic [PARENT_W-1:0] parent;
      logic [COUNT_W-1:0]  count;
      logic                overflow;
      logic                last;
   } weld_result;

   // Shadow copy of the distinct-vertex store and the mesh counters
   logic [COORD_W-1:0]  shadow_x      [CAPACITY];
   logic [COORD_W-1:0]  shadow_y      [CAPACITY];
   logic [COORD_W-1:0]  shadow_z      [CAPACITY];
   logic [PARENT_W-1:0] shadow_origin [CAPACITY];
   int unsigned         vertex_total;
   int unsigned         distinct_total;
   logic                mesh_overflow;

   weld_result expected_welds[$];

   initial begin
      vertex_total     = 0;
      distinct_total   = 0;
      mesh_overflow    = 1'b0;
      mismatches       = 0;
      pending          = 0;
      results_checked  = 0;
      overflow_results = 0;
   end

   function automatic logic coord_is_nan(input logic [COORD_W-1:0] b);
      return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
   endfunction

   // Equal as values: signed zeros agree, NaN agrees with nothing
   function automatic logic coord_equal(input logic [COORD_W-1:0] a,
                                        input logic [COORD_W-1:0] b);
      if (coord_is_nan(a) || coord_is_nan(b))
         return 1'b0;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
         return 1'b1;
      return a == b;
   endfunction

   // Weld one vertex against the shadow store and return its result word
   function automatic weld_result weld_vertex(input logic [COORD_W-1:0] x,
                                              input logic [COORD_W-1:0] y,
                                              input logic [COORD_W-1:0] z,
                                              input logic last);
      weld_result  r;
      int unsigned k;
      logic        found;
      r      = '0;
      r.last = last;
      found  = 1'b0;
      if (vertex_total >= CAPACITY) begin
         mesh_overflow = 1'b1;
      end else begin
         r.parent = vertex_total[PARENT_W-1:0];
         for (k = 0; k < distinct_total && !found; k++) begin
            if (coord_equal(shadow_x[k], x) && coord_equal(shadow_y[k], y) &&
                coord_equal(shadow_z[k], z)) begin
               r.parent = shadow_origin[k];
               found    = 1'b1;
            end
         end
         if (!found && distinct_total < CAPACITY) begin
            shadow_x[distinct_total]      = x;
            shadow_y[distinct_total]      = y;
            shadow_z[distinct_total]      = z;
            shadow_origin[distinct_total] = vertex_total[PARENT_W-1:0];
            distinct_total++;
         end
         vertex_total++;
      end
      r.count    = distinct_total[COUNT_W-1:0];
      r.overflow = mesh_overflow;
      // Empty the store once the mesh ends
      if (last) begin
         vertex_total   = 0;
         distinct_total = 0;
         mesh_overflow  = 1'b0;
      end
      return r;
   endfunction

   task automatic flag_field(input string field, input longint unsigned want,
                             input longint unsigned got);
      mismatches++;
      if (mismatches <= 10)
         $display("weld check: %s wrong on result %0d: expected %0h, got %0h",
                  field, results_checked, want, got);
   endtask

   // Retire result words first, then queue the prediction for a new vertex
   always @(posedge clock) begin
      weld_result want;
      if (reset) begin
         vertex_total   = 0;
         distinct_total = 0;
         mesh_overflow  = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_welds.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("weld check: result word with nothing expected, parent %0h",
                           rsp_parent_index);
            end else begin
               want = expected_welds.pop_front();
               if (rsp_parent_index !== want.parent)
                  flag_field("parent_index", want.parent, rsp_parent_index);
               if (rsp_distinct_count !== want.count)
                  flag_field("distinct_count", want.count, rsp_distinct_count);
               if (rsp_overflow !== want.overflow)
                  flag_field("overflow", want.overflow, rsp_overflow);
               if (rsp_final_result !== want.last)
                  flag_field("final_result", want.last, rsp_final_result);
               if (want.overflow)
                  overflow_results++;
            end
            results_checked++;
         end
         if (req_valid && req_ready)
            expected_welds.push_back(weld_vertex(req_coord_x, req_coord_y, req_coord_z,
                                                 req_final_vertex));
      end
      pending = expected_welds.size();
   end

endmodule

>>> tb/sv/tb_exact_vertex_weld_unit.sv
module tb_exact_vertex_weld_unit;
   import evw_pkg::*;

   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int LONG_HOLD       = 300;
   localparam int DRAIN_CYCLES    = 40;
   localparam int RANDOM_VERTICES = 100;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
   } coord_triple;

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [COORD_W-1:0]  req_coord_x;
   logic [COORD_W-1:0]  req_coord_y;
   logic [COORD_W-1:0]  req_coord_z;
   logic                req_final_vertex;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [PARENT_W-1:0] rsp_parent_index;
   logic [COUNT_W-1:0]  rsp_distinct_count;
   logic                rsp_overflow;
   logic                rsp_final_result;

   int unsigned mismatches;
   int unsigned pending;
   int unsigned results_checked;
   int unsigned overflow_results;

   int unsigned cycle_count   = 0;
   int unsigned vertices_sent = 0;
   int unsigned meshes_sent   = 0;
   int unsigned hold_requests = 0;
   logic        steady_mode   = 1'b0;

   exact_vertex_weld_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .req_coord_z        (req_coord_z),
      .req_final_vertex   (req_final_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_parent_index   (rsp_parent_index),
      .rsp_distinct_count (rsp_distinct_count),
      .rsp_overflow       (rsp_overflow),
      .rsp_final_result   (rsp_final_result)
   );

   exact_vertex_weld_checker weld_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .req_coord_z        (req_coord_z),
      .req_final_vertex   (req_final_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_parent_index   (rsp_parent_index),
      .rsp_distinct_count (rsp_distinct_count),
      .rsp_overflow       (rsp_overflow),
      .rsp_final_result   (rsp_final_result),
      .mismatches         (mismatches),
      .pending            (pending),
      .results_checked    (results_checked),
      .overflow_results   (overflow_results)
   );

   always #1 clock = ~clock;

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Mix of special encodings and plain random bit patterns
   function automatic logic [COORD_W-1:0] fresh_coord();
      if ($urandom_range(0, 3) != 0)
         return $urandom;
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'h8000_0000;
         2:       return 32'h7F80_0000;
         3:       return 32'hFF80_0000;
         4:       return 32'h7FC0_0000;
         5:       return 32'hFFFF_FFFF;
         6:       return 32'h0000_0001;
         7:       return 32'h8000_0001;
         8:       return 32'h7F7F_FFFF;
         default: return 32'h3F80_0000;
      endcase
   endfunction

   // Receiver: random stalls, with one long hold-off on request
   initial begin
      int idle_left;
      int unsigned hold_served;
      idle_left   = 0;
      hold_served = 0;
      rsp_ready   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            idle_left   = LONG_HOLD;
         end
         if (idle_left > 0) begin
            rsp_ready <= 1'b0;
            idle_left--;
         end else begin
            rsp_ready <= 1'b1;
            if (!steady_mode && $urandom_range(0, 3) == 0)
               idle_left = pick_gap();
         end
      end
   end

   // Offer one vertex word, hold it until taken, then drop valid for a random gap outside steady mode
   task automatic send_vertex(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic [COORD_W-1:0] z, input logic last);
      int gap;
      req_coord_x      <= x;
      req_coord_y      <= y;
      req_coord_z      <= z;
      req_final_vertex <= last;
      req_valid        <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      vertices_sent++;
      if (last)
         meshes_sent++;
      gap = steady_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drop valid and wait for every outstanding result word
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
   endtask

   // One mesh with repeats, signed-zero twins and NaN vertices mixed in
   task automatic random_mesh(input int length);
      coord_triple pool[$];
      coord_triple v;
      int          i;
      int          pick;
      for (i = 0; i < length; i++) begin
         pick = $urandom_range(0, 9);
         if (pool.size() > 0 && pick < 5) begin
            v = pool[$urandom_range(0, pool.size() - 1)];
            if ($urandom_range(0, 1)) begin
               if (v.x[30:0] == 31'd0) v.x[31] = ~v.x[31];
               if (v.y[30:0] == 31'd0) v.y[31] = ~v.y[31];
               if (v.z[30:0] == 31'd0) v.z[31] = ~v.z[31];
            end
         end else if (pool.size() > 0 && pick < 6) begin
            v   = pool[$urandom_range(0, pool.size() - 1)];
            v.y = {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
         end else begin
            v.x = fresh_coord();
            v.y = fresh_coord();
            v.z = fresh_coord();
            pool.push_back(v);
         end
         send_vertex(v.x, v.y, v.z, i == length - 1);
      end
   endtask

   initial begin
      int          random_sent;
      int          len;
      logic        hold_done;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_coord_x      = '0;
      req_coord_y      = '0;
      req_coord_z      = '0;
      req_final_vertex = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed mesh: zeros, NaN, infinities, subnormals, one-ulp differences
      send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_vertex(32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 1'b0);
      send_vertex(32'h7FC0_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
      send_vertex(32'h7FC0_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
      send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_vertex(32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000, 1'b0);
      send_vertex(32'h7F80_0000, 32'h7F80_0000, 32'h7F80_0000, 1'b0);
      send_vertex(32'hFF80_0000, 32'h7F80_0000, 32'h7F80_0000, 1'b0);
      send_vertex(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 1'b0);
      send_vertex(32'h3F80_0000, 32'h4000_0000, 32'h4040_0001, 1'b0);
      send_vertex(32'h0000_0001, 32'h8000_0001, 32'h7F7F_FFFF, 1'b0);
      send_vertex(32'h8000_0001, 32'h8000_0001, 32'h7F7F_FFFF, 1'b0);
      send_vertex(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 1'b1);
      // Single-vertex meshes right after a mesh end
      send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
      send_vertex(32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
      wait_drained();

      // Random meshes; one of them runs against a long receiver hold-off
      random_sent = 0;
      hold_done   = 1'b0;
      while (random_sent < RANDOM_VERTICES) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 20);
         steady_mode = ($urandom_range(0, 3) == 0);
         if (!hold_done && random_sent >= RANDOM_VERTICES / 2) begin
            hold_done = 1'b1;
            hold_requests++;
            steady_mode = 1'b1;
         end
         random_mesh(len);
         random_sent += len;
         if ($urandom_range(0, 2) == 0)
            wait_drained();
      end
      steady_mode = 1'b0;

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("tb: sent %0d vertices in %0d meshes with repeats, signed zeros and NaN",
               vertices_sent, meshes_sent);
      $display("tb: checked %0d result words, %0d flagged overflow, %0d mismatches",
               results_checked, overflow_results, mismatches);
      if (mismatches == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
